@@ sv/fb_pixel_format_converter_macros.svh @@
// Assertion macros used by the framebuffer pixel format converter core.
`ifndef FB_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define FB_PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Clocked assertion on clk, disabled while arst_n is low.
`define FBPFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication on clk, disabled while arst_n is low.
`define FBPFC_ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

`endif

@@ sv/fbpfc_pkg.sv @@
// Package with the types and constants of the framebuffer pixel format converter.
`timescale 1ns / 1ps

package fbpfc_pkg;

	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DEPTH_W = 6;

	localparam logic [DEPTH_W-1:0] DEPTH_8  = 6'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_15 = 6'd15;
	localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
	localparam logic [DEPTH_W-1:0] DEPTH_24 = 6'd24;
	localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;

	localparam logic ORDER_BGR = 1'b0;
	localparam logic ORDER_RGB = 1'b1;

	typedef enum logic [1:0] {
		REG_SOURCE_DEPTH = 2'd0,
		REG_PIXEL_ORDER  = 2'd1,
		REG_DEST_DEPTH   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] source_depth;
		logic               pixel_order;
		logic [DEPTH_W-1:0] dest_depth;
	} cfg_t;

endpackage

@@ sv/fbpfc_if.sv @@
// Valid/ready channel interfaces for the source pixel and the converted pixel.
`timescale 1ns / 1ps

interface fbpfc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_word;
	logic [31:0] palette_word;

	modport source(output valid, output source_word, output palette_word, input ready);
	modport sink(input valid, input source_word, input palette_word, output ready);
endinterface

interface fbpfc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;
	logic [2:0]  dest_bytes;
	logic [2:0]  source_bytes_used;

	modport source(output valid, output pixel_word, output dest_bytes,
		output source_bytes_used, input ready);
	modport sink(input valid, input pixel_word, input dest_bytes,
		input source_bytes_used, output ready);
endinterface

@@ sv/fbpfc_regs.sv @@
// APB configuration registers of the pixel format converter.
`timescale 1ns / 1ps

module fbpfc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbpfc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output fbpfc_pkg::cfg_t               cfg
);

	fbpfc_pkg::cfg_t      cfg_q;
	fbpfc_pkg::reg_idx_t  reg_idx;
	logic                 wr_en;

	assign reg_idx = fbpfc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_depth <= fbpfc_pkg::DEPTH_16;
			cfg_q.pixel_order  <= fbpfc_pkg::ORDER_RGB;
			cfg_q.dest_depth   <= fbpfc_pkg::DEPTH_32;
		end else if (wr_en) begin
			unique case (reg_idx)
				fbpfc_pkg::REG_SOURCE_DEPTH: cfg_q.source_depth <= pwdata[5:0];
				fbpfc_pkg::REG_PIXEL_ORDER:  cfg_q.pixel_order  <= pwdata[0];
				fbpfc_pkg::REG_DEST_DEPTH:   cfg_q.dest_depth   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fbpfc_pkg::REG_SOURCE_DEPTH: prdata = {26'd0, cfg_q.source_depth};
			fbpfc_pkg::REG_PIXEL_ORDER:  prdata = {31'd0, cfg_q.pixel_order};
			fbpfc_pkg::REG_DEST_DEPTH:   prdata = {26'd0, cfg_q.dest_depth};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/fbpfc_core.sv @@
// Two-stage conversion pipeline: input register, decode and pack, result register.
`timescale 1ns / 1ps
`include "fb_pixel_format_converter_macros.svh"

module fbpfc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  fbpfc_pkg::cfg_t  cfg,
	fbpfc_in_if.sink         src,
	fbpfc_out_if.source      dst
);

	logic        valid_s1;
	logic [31:0] source_word_s1;
	logic [31:0] palette_word_s1;

	logic        valid_s2;
	logic [31:0] pixel_word_s2;
	logic [2:0]  dest_bytes_s2;
	logic [2:0]  used_s2;

	logic        adv_s2;
	logic        in_xfer;

	logic [7:0]  red_dec, green_dec, blue_dec;
	logic [7:0]  red, green, blue;
	logic [2:0]  used;
	logic [31:0] pixel;
	logic [2:0]  nbytes;

	assign adv_s2    = !valid_s2 || dst.ready;
	assign src.ready = !valid_s1 || adv_s2;
	assign in_xfer   = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			source_word_s1  <= src.source_word;
			palette_word_s1 <= src.palette_word;
		end
	end

	// Decode the source pixel into 8-bit components.
	always_comb begin
		red_dec   = 8'd0;
		green_dec = 8'd0;
		blue_dec  = 8'd0;
		used      = 3'd0;
		case (cfg.source_depth) inside
			fbpfc_pkg::DEPTH_8: begin
				red_dec   = palette_word_s1[7:0];
				green_dec = palette_word_s1[15:8];
				blue_dec  = palette_word_s1[23:16];
				used      = 3'd1;
			end
			fbpfc_pkg::DEPTH_16: begin
				red_dec   = {source_word_s1[15:11], 3'd0};
				green_dec = {source_word_s1[10:5], 2'd0};
				blue_dec  = {source_word_s1[4:0], 3'd0};
				used      = 3'd2;
			end
			fbpfc_pkg::DEPTH_24, fbpfc_pkg::DEPTH_32: begin
				red_dec   = source_word_s1[7:0];
				green_dec = source_word_s1[15:8];
				blue_dec  = source_word_s1[23:16];
				used      = cfg.source_depth[5:3];
			end
			default: ;
		endcase
	end

	assign red   = (cfg.pixel_order == fbpfc_pkg::ORDER_BGR) ? blue_dec : red_dec;
	assign green = green_dec;
	assign blue  = (cfg.pixel_order == fbpfc_pkg::ORDER_BGR) ? red_dec : blue_dec;

	// Pack the components for the surface format.
	always_comb begin
		pixel  = 32'd0;
		nbytes = 3'd0;
		case (cfg.dest_depth) inside
			fbpfc_pkg::DEPTH_8: begin
				pixel  = {24'd0, red[7:5], green[7:5], blue[7:6]};
				nbytes = 3'd1;
			end
			fbpfc_pkg::DEPTH_15: begin
				pixel  = {17'd0, red[7:3], green[7:3], blue[7:3]};
				nbytes = 3'd2;
			end
			fbpfc_pkg::DEPTH_16: begin
				pixel  = {16'd0, red[7:3], green[7:2], blue[7:3]};
				nbytes = 3'd2;
			end
			fbpfc_pkg::DEPTH_24, fbpfc_pkg::DEPTH_32: begin
				pixel  = {8'd0, red, green, blue};
				nbytes = cfg.dest_depth[5:3];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_word_s2 <= pixel;
			dest_bytes_s2 <= nbytes;
			used_s2       <= used;
		end
	end

	assign dst.valid             = valid_s2;
	assign dst.pixel_word        = pixel_word_s2;
	assign dst.dest_bytes        = dest_bytes_s2;
	assign dst.source_bytes_used = used_s2;

	`FBPFC_ASSERT(a_in_lands_s1, in_xfer |=> valid_s1, "accepted transfer did not reach stage one")
	`FBPFC_ASSERT(a_s1_held, (valid_s1 && !adv_s2) |=> valid_s1, "stage one dropped a stalled pixel")
	`FBPFC_ASSERT_IMPL(a_unsup_dest_zero, valid_s2 && dest_bytes_s2 == 3'd0,
		pixel_word_s2 == 32'd0, "unsupported surface depth gave a nonzero pixel")
	`FBPFC_ASSERT_IMPL(a_unknown_src_black, valid_s2 && used_s2 == 3'd0,
		pixel_word_s2 == 32'd0, "unknown source depth did not give black")

endmodule

@@ sv/fb_pixel_format_converter.sv @@
// Pipeline: an accepted input passes the stage-one and stage-two registers to dst.
// Throughput: one pixel per cycle unless dst stalls; a result register after the
// convert logic lets a new pixel enter while the previous result waits for its
// transfer. Reset: arst_n clears both pipeline stages and sets source depth 16, RGB
// order, surface depth 32.
`timescale 1ns / 1ps

module fb_pixel_format_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	fbpfc_in_if.sink                      src,
	fbpfc_out_if.source                   dst,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbpfc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	fbpfc_pkg::cfg_t cfg;

	fbpfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fbpfc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.src    (src),
		.dst    (dst)
	);

endmodule
